@@ design/skeleton_absolute_transform_assert.svh @@
// assertion macros for the checker file
`ifndef SKELETON_ABSOLUTE_TRANSFORM_ASSERT_SVH
`define SKELETON_ABSOLUTE_TRANSFORM_ASSERT_SVH

// implication in the same cycle, off while reset is held
`define SKAT_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("skat assertion failed");

// implication in the next cycle, active during reset too
`define SKAT_ASSERT_NEXT_NORST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("skat assertion failed");

`endif

@@ design/skat_pkg.sv @@
// shared types and codes of the skeleton transform block
package skat_pkg;

    localparam int SKAT_MAX_JOINTS = 256;

    // joint classes decided at the front
    localparam logic [1:0] KIND_ROOT = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_COMP = 2'd2;

    typedef struct packed {
        logic signed [15:0] local_orient_w;
        logic signed [15:0] local_orient_x;
        logic signed [15:0] local_orient_y;
        logic signed [15:0] local_orient_z;
        logic signed [31:0] local_pos_x;
        logic signed [31:0] local_pos_y;
        logic signed [31:0] local_pos_z;
        logic [7:0]         parent_index;
        logic               last_joint;
    } skat_in_t;

    typedef struct packed {
        logic signed [15:0] abs_orient_w;
        logic signed [15:0] abs_orient_x;
        logic signed [15:0] abs_orient_y;
        logic signed [15:0] abs_orient_z;
        logic signed [31:0] abs_pos_x;
        logic signed [31:0] abs_pos_y;
        logic signed [31:0] abs_pos_z;
        logic               parent_error;
        logic               end_of_skeleton;
    } skat_out_t;

    // one stored absolute transform
    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } skat_xform_t;

endpackage

@@ design/skat_ram.sv @@
// generic single write port ram with registered read
module skat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ design/skat_queue.sv @@
// two entry queue between front and back
module skat_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);
    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end
endmodule

@@ design/skat_front.sv @@
// input side: joint numbering and classification
module skat_front import skat_pkg::*; #(
    parameter int MAX_JOINTS = SKAT_MAX_JOINTS,
    parameter int IDX_W      = $clog2(MAX_JOINTS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  skat_in_t         s_data,
    input  logic             q_full,
    output logic             q_push,
    output logic [IDX_W-1:0] q_idx,
    output logic [1:0]       q_kind,
    output skat_in_t         q_item
);
    localparam int CW = (IDX_W > 8) ? IDX_W : 8;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]    parent_ext;
    logic [CW-1:0]    idx_ext;

    assign s_ready    = !q_full;
    assign q_push     = s_valid && !q_full;
    assign q_idx      = idx_reg;
    assign q_item     = s_data;
    assign parent_ext = CW'(s_data.parent_index);
    assign idx_ext    = CW'(idx_reg);

    always_comb begin
        if (idx_reg == '0) begin
            q_kind = KIND_ROOT;
        end else if (parent_ext >= idx_ext) begin
            q_kind = KIND_ERR;
        end else begin
            q_kind = KIND_COMP;
        end
        idx_next = idx_reg;
        if (q_push) begin
            if (s_data.last_joint || idx_reg == IDX_W'(MAX_JOINTS - 1)) begin
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end
endmodule

@@ design/skat_back.sv @@
// execution side: parent fetch, quaternion product, rotation, store, output
module skat_back import skat_pkg::*; #(
    parameter int MAX_JOINTS = SKAT_MAX_JOINTS,
    parameter int IDX_W      = $clog2(MAX_JOINTS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    output logic             q_pop,
    input  logic [IDX_W-1:0] q_idx,
    input  logic [1:0]       q_kind,
    input  skat_in_t         q_item,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_waddr,
    output skat_xform_t      ram_wdata,
    output logic             ram_re,
    output logic [IDX_W-1:0] ram_raddr,
    input  skat_xform_t      ram_rdata,
    output logic             m_valid,
    input  logic             m_ready,
    output skat_out_t        m_data
);
    localparam int CW = (IDX_W > 8) ? IDX_W : 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [3:0] STEP_LAST = 4'd12;

    function automatic logic signed [15:0] rnd_sat16(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767) begin
            return 16'sh7fff;
        end else if (r < -34'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    function automatic logic signed [23:0] rnd_m(input logic signed [33:0] v);
        logic signed [33:0] r;
        r = (v + 34'sd512) >>> 10;
        return r[23:0];
    endfunction

    function automatic logic signed [31:0] pos_out(input logic signed [57:0] acc,
                                                   input logic signed [31:0] par);
        logic signed [57:0] r;
        logic signed [38:0] t;
        r = (acc + 58'sd524288) >>> 20;
        t = 39'(par) + 39'(r);
        if (t > 39'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (t < -39'sd2147483648) begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction

    logic [1:0]         state_reg, state_next;
    logic [3:0]         step_reg, step_next;
    logic [3:0]         cons;
    skat_in_t           cur_reg;
    logic [IDX_W-1:0]   cur_idx_reg;
    skat_xform_t        res_reg;
    logic               err_reg;
    logic               out_vld_reg, out_vld_next;
    skat_out_t          out_reg;
    logic               out_free;
    logic [CW-1:0]      parent_ext;

    logic signed [15:0] ma [4];
    logic signed [15:0] mb [4];
    logic signed [31:0] prod_reg [4];
    logic signed [23:0] mc [3];
    logic signed [31:0] md [3];
    logic signed [55:0] wprod_reg [3];

    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    logic signed [31:0] wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [23:0] m_reg [9];
    logic signed [33:0] msum [9];
    logic signed [33:0] qsum [4];
    logic signed [57:0] acc;

    skat_xform_t par;

    assign par        = ram_rdata;
    assign cons       = step_reg - 4'd1;
    assign out_free   = !out_vld_reg || m_ready;
    assign q_pop      = (state_reg == ST_IDLE) && !q_empty;
    assign parent_ext = CW'(cur_reg.parent_index);
    assign ram_re     = (state_reg == ST_READ);
    assign ram_raddr  = parent_ext[IDX_W-1:0];
    assign ram_we     = (state_reg == ST_DONE) && out_free;
    assign ram_waddr  = cur_idx_reg;
    assign ram_wdata  = res_reg;
    assign m_valid    = out_vld_reg;
    assign m_data     = out_reg;

    // multiplier operand selection per step
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ma[i] = '0;
            mb[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            mc[i] = '0;
            md[i] = '0;
        end
        case (step_reg)
            4'd0: begin
                ma = '{par.w, par.x, par.y, par.z};
                mb = '{cur_reg.local_orient_w, cur_reg.local_orient_x,
                       cur_reg.local_orient_y, cur_reg.local_orient_z};
            end
            4'd1: begin
                ma = '{par.w, par.x, par.y, par.z};
                mb = '{cur_reg.local_orient_x, cur_reg.local_orient_w,
                       cur_reg.local_orient_z, cur_reg.local_orient_y};
            end
            4'd2: begin
                ma = '{par.w, par.x, par.y, par.z};
                mb = '{cur_reg.local_orient_y, cur_reg.local_orient_z,
                       cur_reg.local_orient_w, cur_reg.local_orient_x};
            end
            4'd3: begin
                ma = '{par.w, par.x, par.y, par.z};
                mb = '{cur_reg.local_orient_z, cur_reg.local_orient_y,
                       cur_reg.local_orient_x, cur_reg.local_orient_w};
            end
            4'd4: begin
                ma = '{par.w, par.x, par.y, par.z};
                mb = '{par.w, par.x, par.y, par.z};
            end
            4'd5: begin
                ma = '{par.x, par.w, par.x, par.w};
                mb = '{par.y, par.z, par.z, par.y};
            end
            4'd6: begin
                ma[0] = par.y;
                mb[0] = par.z;
                ma[1] = par.w;
                mb[1] = par.x;
            end
            4'd9, 4'd10, 4'd11: begin
                for (int i = 0; i < 3; i++) begin
                    mc[i] = m_reg[3 * (int'(step_reg) - 9) + i];
                end
                md = '{cur_reg.local_pos_x, cur_reg.local_pos_y, cur_reg.local_pos_z};
            end
            default: begin
            end
        endcase
    end

    // sums taken from the product registers
    always_comb begin
        qsum[0] = 34'(prod_reg[0]) - 34'(prod_reg[1]) - 34'(prod_reg[2]) - 34'(prod_reg[3]);
        qsum[1] = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) - 34'(prod_reg[3]);
        qsum[2] = 34'(prod_reg[0]) - 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        qsum[3] = 34'(prod_reg[0]) + 34'(prod_reg[1]) - 34'(prod_reg[2]) + 34'(prod_reg[3]);
        msum[0] = 34'(ww_reg) + 34'(xx_reg) - 34'(yy_reg) - 34'(zz_reg);
        msum[1] = (34'(xy_reg) - 34'(wz_reg)) <<< 1;
        msum[2] = (34'(xz_reg) + 34'(wy_reg)) <<< 1;
        msum[3] = (34'(xy_reg) + 34'(wz_reg)) <<< 1;
        msum[4] = 34'(ww_reg) - 34'(xx_reg) + 34'(yy_reg) - 34'(zz_reg);
        msum[5] = (34'(yz_reg) - 34'(wx_reg)) <<< 1;
        msum[6] = (34'(xz_reg) - 34'(wy_reg)) <<< 1;
        msum[7] = (34'(yz_reg) + 34'(wx_reg)) <<< 1;
        msum[8] = 34'(ww_reg) - 34'(xx_reg) - 34'(yy_reg) + 34'(zz_reg);
        acc     = 58'(wprod_reg[0]) + 58'(wprod_reg[1]) + 58'(wprod_reg[2]);
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        out_vld_next = out_vld_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (!q_empty) begin
                    state_next = (q_kind == KIND_COMP) ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            prod_reg[i] <= ma[i] * mb[i];
        end
        for (int i = 0; i < 3; i++) begin
            wprod_reg[i] <= mc[i] * md[i];
        end
        if (q_pop) begin
            cur_reg     <= q_item;
            cur_idx_reg <= q_idx;
            err_reg     <= (q_kind == KIND_ERR);
            res_reg.w   <= q_item.local_orient_w;
            res_reg.x   <= q_item.local_orient_x;
            res_reg.y   <= q_item.local_orient_y;
            res_reg.z   <= q_item.local_orient_z;
            if (q_kind == KIND_ROOT) begin
                res_reg.px <= '0;
                res_reg.py <= '0;
                res_reg.pz <= '0;
            end else begin
                res_reg.px <= q_item.local_pos_x;
                res_reg.py <= q_item.local_pos_y;
                res_reg.pz <= q_item.local_pos_z;
            end
        end
        if (state_reg == ST_CALC && step_reg != 4'd0) begin
            case (cons)
                4'd0: res_reg.w <= rnd_sat16(qsum[0]);
                4'd1: res_reg.x <= rnd_sat16(qsum[1]);
                4'd2: res_reg.y <= rnd_sat16(qsum[2]);
                4'd3: res_reg.z <= rnd_sat16(qsum[3]);
                4'd4: begin
                    ww_reg <= prod_reg[0];
                    xx_reg <= prod_reg[1];
                    yy_reg <= prod_reg[2];
                    zz_reg <= prod_reg[3];
                end
                4'd5: begin
                    xy_reg <= prod_reg[0];
                    wz_reg <= prod_reg[1];
                    xz_reg <= prod_reg[2];
                    wy_reg <= prod_reg[3];
                end
                4'd6: begin
                    yz_reg <= prod_reg[0];
                    wx_reg <= prod_reg[1];
                end
                4'd7: begin
                    for (int i = 0; i < 9; i++) begin
                        m_reg[i] <= rnd_m(msum[i]);
                    end
                end
                4'd9:  res_reg.px <= pos_out(acc, par.px);
                4'd10: res_reg.py <= pos_out(acc, par.py);
                4'd11: res_reg.pz <= pos_out(acc, par.pz);
                default: begin
                end
            endcase
        end
        if (ram_we) begin
            out_reg.abs_orient_w    <= res_reg.w;
            out_reg.abs_orient_x    <= res_reg.x;
            out_reg.abs_orient_y    <= res_reg.y;
            out_reg.abs_orient_z    <= res_reg.z;
            out_reg.abs_pos_x       <= res_reg.px;
            out_reg.abs_pos_y       <= res_reg.py;
            out_reg.abs_pos_z       <= res_reg.pz;
            out_reg.parent_error    <= err_reg;
            out_reg.end_of_skeleton <= cur_reg.last_joint;
        end
    end
endmodule

@@ design/skeleton_absolute_transform.sv @@
// top level of the skeleton absolute transform block
//
// input channel s_valid/s_ready/s_data carries one joint item in index order;
// output channel m_valid/m_ready/m_data returns one absolute transform per item
// joint 0 of each skeleton passes its orientation with zero position, a joint
// whose parent is not below its own index passes unchanged with parent_error
// the joint counter restarts after last_joint or after index MAX_JOINTS-1
// the front numbers and classifies items into a two entry queue, so input is
// taken while the back is busy or the output waits
// the back runs one joint at a time: a composed joint goes through pop,
// parent read, 13 steps of four 16x16 and three 24x32 multipliers, and store;
// a root or error joint goes from pop straight to store; the store waits for
// a free output register, and m_valid rises for each stored joint
// the store is a ram of MAX_JOINTS entries, written once per joint, read once
// for the parent of a composed joint, and needs no clearing after reset
// reset (aresetn low, synchronous) empties the queue, drops a pending result
// and restarts the joint counter at zero
// a stalled receiver holds the result in the output register; the back then
// waits and the queue fills, after which s_ready falls
module skeleton_absolute_transform import skat_pkg::*; #(
    parameter int MAX_JOINTS = SKAT_MAX_JOINTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  skat_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output skat_out_t m_data
);
    localparam int IDX_W = $clog2(MAX_JOINTS);
    localparam int QW    = IDX_W + 2 + $bits(skat_in_t);

    // front to queue
    logic             f_push;
    logic [IDX_W-1:0] f_idx;
    logic [1:0]       f_kind;
    skat_in_t         f_item;

    // queue to back
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [QW-1:0]    q_dout;
    logic [IDX_W-1:0] b_idx;
    logic [1:0]       b_kind;
    skat_in_t         b_item;

    // transform store
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    skat_xform_t      ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    skat_xform_t      ram_rdata;

    assign {b_idx, b_kind, b_item} = q_dout;

    skat_front #(.MAX_JOINTS(MAX_JOINTS), .IDX_W(IDX_W)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (f_push),
        .q_idx   (f_idx),
        .q_kind  (f_kind),
        .q_item  (f_item)
    );

    // short queue decouples numbering from execution
    skat_queue #(.W(QW)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_push),
        .din     ({f_idx, f_kind, f_item}),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    skat_back #(.MAX_JOINTS(MAX_JOINTS), .IDX_W(IDX_W)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_idx     (b_idx),
        .q_kind    (b_kind),
        .q_item    (b_item),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // absolute transforms of earlier joints, one entry per joint index
    skat_ram #(.WIDTH($bits(skat_xform_t)), .DEPTH(MAX_JOINTS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

@@ design/skat_checker.sv @@
// port level checks for the skeleton transform block, with bind
`include "skeleton_absolute_transform_assert.svh"

module skat_checker import skat_pkg::*; #(
    parameter int MAX_JOINTS = SKAT_MAX_JOINTS
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input skat_out_t m_data
);
    localparam int IDX_W = $clog2(MAX_JOINTS);

    logic [2:0]       pend_reg, pend_next;
    logic [IDX_W-1:0] jcnt_reg, jcnt_next;
    logic             in_acc;
    logic             out_acc;
    logic             root_ok;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;
    assign root_ok = (m_data.abs_pos_x == 32'sd0) && (m_data.abs_pos_y == 32'sd0)
                     && (m_data.abs_pos_z == 32'sd0) && !m_data.parent_error;

    always_comb begin
        pend_next = pend_reg + {2'b0, in_acc} - {2'b0, out_acc};
        jcnt_next = jcnt_reg;
        if (out_acc) begin
            if (m_data.end_of_skeleton || jcnt_reg == IDX_W'(MAX_JOINTS - 1)) begin
                jcnt_next = '0;
            end else begin
                jcnt_next = jcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            jcnt_reg <= '0;
        end else begin
            pend_reg <= pend_next;
            jcnt_reg <= jcnt_next;
        end
    end

    `SKAT_ASSERT_NEXT_NORST(a_reset_quiet, !aresetn, !m_valid)
    `SKAT_ASSERT(a_out_hold, m_valid && !m_ready, ##1 (m_valid && $stable(m_data)))
    `SKAT_ASSERT(a_no_spurious, m_valid, pend_reg != 3'd0)
    `SKAT_ASSERT(a_root_zero, m_valid && jcnt_reg == '0, root_ok)
endmodule

bind skeleton_absolute_transform skat_checker #(.MAX_JOINTS(MAX_JOINTS)) u_skat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ test/tb_skeleton_absolute_transform.sv @@
// testbench for the skeleton absolute transform block
module tb_skeleton_absolute_transform;
    timeunit 1ns;
    timeprecision 1ps;
    import skat_pkg::*;

    localparam int JOINTS = SKAT_MAX_JOINTS;
    localparam int WATCHDOG_LIMIT = 20000;

    // predictor of absolute transforms plus queue of expected results
    class transform_scoreboard;
        skat_xform_t abs_store [JOINTS];
        int unsigned joint_idx;
        skat_out_t expected_results[$];
        int unsigned mismatches;

        function new();
            joint_idx = 0;
            mismatches = 0;
        endfunction

        // round to nearest, ties toward plus infinity
        function longint rnd(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function logic signed [15:0] sat16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function logic signed [31:0] sat32(longint v);
            if (v > 64'sd2147483647) return 32'h7fffffff;
            if (v < -64'sd2147483648) return 32'h80000000;
            return v[31:0];
        endfunction

        // parent composed with local transform
        function skat_xform_t compose(skat_xform_t par, skat_in_t it);
            skat_xform_t r;
            longint w, x, y, z, lw, lx, ly, lz, acc;
            longint m[9];
            longint v[3];
            longint pp[3];
            w = par.w; x = par.x; y = par.y; z = par.z;
            lw = it.local_orient_w; lx = it.local_orient_x;
            ly = it.local_orient_y; lz = it.local_orient_z;
            v[0] = it.local_pos_x; v[1] = it.local_pos_y; v[2] = it.local_pos_z;
            pp[0] = par.px; pp[1] = par.py; pp[2] = par.pz;
            r.w = sat16(rnd(w*lw - x*lx - y*ly - z*lz, 15));
            r.x = sat16(rnd(w*lx + x*lw + y*lz - z*ly, 15));
            r.y = sat16(rnd(w*ly - x*lz + y*lw + z*lx, 15));
            r.z = sat16(rnd(w*lz + x*ly - y*lx + z*lw, 15));
            m[0] = w*w + x*x - y*y - z*z;
            m[1] = 2*(x*y - w*z);
            m[2] = 2*(x*z + w*y);
            m[3] = 2*(x*y + w*z);
            m[4] = w*w - x*x + y*y - z*z;
            m[5] = 2*(y*z - w*x);
            m[6] = 2*(x*z - w*y);
            m[7] = 2*(y*z + w*x);
            m[8] = w*w - x*x - y*y + z*z;
            for (int i = 0; i < 9; i++) m[i] = rnd(m[i], 10);
            for (int i = 0; i < 3; i++) begin
                acc = m[3*i]*v[0] + m[3*i+1]*v[1] + m[3*i+2]*v[2];
                pp[i] = sat32(pp[i] + rnd(acc, 20));
            end
            r.px = pp[0][31:0]; r.py = pp[1][31:0]; r.pz = pp[2][31:0];
            return r;
        endfunction

        function void note_joint(skat_in_t it);
            skat_xform_t r;
            skat_out_t o;
            logic err;
            err = 1'b0;
            r.w = it.local_orient_w; r.x = it.local_orient_x;
            r.y = it.local_orient_y; r.z = it.local_orient_z;
            r.px = it.local_pos_x; r.py = it.local_pos_y; r.pz = it.local_pos_z;
            if (joint_idx == 0) begin
                r.px = '0; r.py = '0; r.pz = '0;
            end else if (it.parent_index >= joint_idx) begin
                err = 1'b1;
            end else begin
                r = compose(abs_store[it.parent_index], it);
            end
            abs_store[joint_idx] = r;
            o = {r.w, r.x, r.y, r.z, r.px, r.py, r.pz, err, it.last_joint};
            expected_results.push_back(o);
            if (it.last_joint || joint_idx + 1 >= JOINTS) joint_idx = 0;
            else joint_idx = joint_idx + 1;
        endfunction

        function void check_result(skat_out_t got);
            skat_out_t exp_o;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_o = expected_results.pop_front();
            if (got !== exp_o) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h actual %h", exp_o, got);
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    skat_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    skat_out_t m_data;

    transform_scoreboard sb = new();
    int send_idle_pct = 0;   // chance in percent of a gap before each item
    int recv_stall_pct = 0;  // chance in percent of a stall cycle
    bit recv_hold = 1'b0;    // long receiver hold-off
    int idle_cycles = 0;
    int sent_in_skel = 0;    // joints offered in the skeleton under way

    always #2 aclk = ~aclk;

    skeleton_absolute_transform dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predict at input accept, check at output accept
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_joint(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver ready pattern
    always @(posedge aclk) begin
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles without any accept
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_skeleton_absolute_transform failed");
            $finish;
        end
    end

    // offer one item and hold it until accepted
    task automatic send_joint(skat_in_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_in_skel = it.last_joint ? 0 : (sent_in_skel + 1) % JOINTS;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
    endtask

    // random quaternion: mostly non-negative w with smaller x, y and z, sometimes any bit pattern
    function automatic skat_in_t rand_joint(bit last);
        skat_in_t it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom)};
        if ($urandom_range(3) != 0) begin
            it.local_orient_w = 16'($urandom_range(32767));
            it.local_orient_x = $signed(16'($urandom)) >>> $urandom_range(4, 1);
            it.local_orient_y = $signed(16'($urandom)) >>> $urandom_range(4, 1);
            it.local_orient_z = $signed(16'($urandom)) >>> $urandom_range(4, 1);
            it.local_pos_x = $signed(it.local_pos_x) >>> $urandom_range(12);
            it.local_pos_y = $signed(it.local_pos_y) >>> $urandom_range(12);
            it.local_pos_z = $signed(it.local_pos_z) >>> $urandom_range(12);
        end
        // valid parent most of the time, broken one now and then
        if (sent_in_skel > 0 && $urandom_range(9) != 0)
            it.parent_index = 8'($urandom_range(sent_in_skel - 1));
        it.last_joint = last;
        return it;
    endfunction

    task automatic random_skeletons(int items);
        int n, len;
        n = 0;
        while (n < items) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(JOINTS, 40)
                                             : $urandom_range(12, 1);
            for (int j = 0; j < len && n < items; j++, n++)
                send_joint(rand_joint(j == len - 1 || n == items - 1));
        end
    endtask

    initial begin
        skat_in_t it;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: root with extremes, identity child, full-scale compose,
        // saturation, invalid parent, skeleton end
        it = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 32'h7fffffff, 32'h80000000,
              32'h12345678, 8'hff, 1'b0};
        send_joint(it);
        it = {16'h7fff, 16'h0000, 16'h0000, 16'h0000, 32'h00010000, 32'hffff0000,
              32'h7fffffff, 8'h00, 1'b0};
        send_joint(it);
        it = {16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 8'h01, 1'b0};
        send_joint(it);
        it = {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'h80000000, 32'h80000000,
              32'h80000000, 8'h02, 1'b0};
        send_joint(it);
        it = {16'h5a82, 16'h5a82, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000,
              32'h00000000, 8'h04, 1'b0};
        send_joint(it);
        it = {16'h1234, 16'hedcb, 16'h0001, 16'hffff, 32'h00020000, 32'h00000001,
              32'hffffffff, 8'hff, 1'b0};
        send_joint(it);
        it = {16'h4000, 16'h4000, 16'h4000, 16'h4000, 32'h0000ffff, 32'h00000000,
              32'h00030000, 8'h03, 1'b1};
        send_joint(it);
        it = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000,
              32'h00000000, 8'h00, 1'b1};
        send_joint(it);
        // overlong skeleton wraps the joint counter
        for (int j = 0; j < JOINTS + 3; j++) send_joint(rand_joint(1'b0));
        send_joint(rand_joint(1'b1));
        drain();

        // four phases: free flow, sender gaps, receiver stalls, then both at a lower rate
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 64 : 20) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 64 : 20) : 0;
            random_skeletons(250);
        end

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (300) @(posedge aclk);
                recv_hold = 1'b0;
            end
            random_skeletons(50);
        join
        random_skeletons(80);
        drain();

        repeat (60) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("tb_skeleton_absolute_transform passed");
        else
            $display("tb_skeleton_absolute_transform failed");
        $finish;
    end
endmodule
